@@ hdl/rplm_pkg.sv @@
// ----------------------------------------------------------------------------
// RE pattern list mask engine package
// Shared constants, opcodes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package rplm_pkg;

   localparam int MAX_PRB_DEF      = 275;
   localparam int SYMS_DEF         = 14;
   localparam int MAX_PATTERNS_DEF = 8;
   localparam int RE_PER_PRB       = 12;

   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_LOAD    = 3'd1;
   localparam logic [2:0] OP_MERGE   = 3'd2;
   localparam logic [2:0] OP_INCLUDE = 3'd3;
   localparam logic [2:0] OP_EXCLUDE = 3'd4;
   localparam logic [2:0] OP_COUNT   = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_M_RD,
      ST_M_CMP,
      ST_M_DEC,
      ST_M_ORRD,
      ST_M_ORWR,
      ST_APPEND,
      ST_Q_RD,
      ST_Q_ACC,
      ST_SUM,
      ST_DONE
   } rplm_state_type;

   typedef enum logic [1:0] {
      ADDR_ENTRY,
      ADDR_TAIL,
      ADDR_QUERY
   } rplm_addr_sel_type;

   typedef struct packed {
      logic              capture;
      logic              list_clear;
      logic              stage_load;
      logic              idx_clear;
      logic              word_clear;
      logic              word_next;
      logic              entry_next;
      logic              mem_rd;
      logic              mem_wr;
      rplm_addr_sel_type addr_sel;
      logic              cmp_word;
      logic              sc_or;
      logic              sym_or;
      logic              append_meta;
      logic              set_full;
      logic              set_outside;
      logic              query_acc;
      logic              sum_step;
      logic              out_load;
   } rplm_cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       in_bw;
      logic       list_empty;
      logic       list_full;
      logic       last_word;
      logic       last_entry;
      logic       last_sym;
      logic       crb_eq;
      logic       sym_eq;
      logic       sc_eq;
   } rplm_stat_type;

   function automatic logic [3:0] popcount12(input logic [RE_PER_PRB-1:0] v);
      logic [3:0] n;
      n = '0;
      for (int k = 0; k < RE_PER_PRB; k++) begin
         n = n + {3'd0, v[k]};
      end
      return n;
   endfunction

endpackage

@@ hdl/re_pattern_list_mask_engine.sv @@
// Clear and load act in the execute state; merge reads and compares each stored
// pattern word by word, then appends the staged pattern or ORs it into a matching
// entry; include/exclude read one word per stored pattern; count then sums symbols.
// One item in flight; the one-port pattern memory read per word sets the pace.
// Synchronous reset: list empty, staging words and count zero, num_prb = 275.
// ----------------------------------------------------------------------------
// RE pattern list mask engine
// Pattern list with merge, per-PRB RE mask include/exclude and RE counting.
// ----------------------------------------------------------------------------
module re_pattern_list_mask_engine
   import rplm_pkg::*;
#(
   parameter int MAX_PRB          = MAX_PRB_DEF,
   parameter int SYMBOLS_PER_SLOT = SYMS_DEF,
   parameter int MAX_PATTERNS     = MAX_PATTERNS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [2:0]  req_word_index,
   input  logic [63:0] req_crb_word,
   input  logic [13:0] req_symbol_mask,
   input  logic [11:0] req_subcarrier_mask,
   input  logic [3:0]  req_symbol,
   input  logic [3:0]  req_symbol_count,
   input  logic [8:0]  req_prb,
   input  logic [11:0] req_mask_in,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_mask_out,
   output logic [15:0] rsp_running_count,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);

   rplm_cmd_type  cmd;
   rplm_stat_type stat;

   rplm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rplm_dp #(
      .MAX_PRB      (MAX_PRB),
      .SYMS         (SYMBOLS_PER_SLOT),
      .MAX_PATTERNS (MAX_PATTERNS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_opcode          (req_opcode),
      .req_word_index      (req_word_index),
      .req_crb_word        (req_crb_word),
      .req_symbol_mask     (req_symbol_mask),
      .req_subcarrier_mask (req_subcarrier_mask),
      .req_symbol          (req_symbol),
      .req_symbol_count    (req_symbol_count),
      .req_prb             (req_prb),
      .req_mask_in         (req_mask_in),
      .req_restart         (req_restart),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_mask_out        (rsp_mask_out),
      .rsp_running_count   (rsp_running_count),
      .rsp_status          (rsp_status)
   );

endmodule

@@ hdl/rplm_ctrl.sv @@
// ----------------------------------------------------------------------------
// RE pattern list mask engine controller
// Sequences clear, load, merge scan, mask query and count over the datapath.
// ----------------------------------------------------------------------------
module rplm_ctrl
   import rplm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  rplm_stat_type stat,
   output rplm_cmd_type  cmd
);

   rplm_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.addr_sel = ADDR_ENTRY;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.opcode)
               OP_CLEAR: begin
                  cmd.list_clear = 1'b1;
                  state_in       = ST_DONE;
               end
               OP_LOAD: begin
                  cmd.stage_load = 1'b1;
                  state_in       = ST_DONE;
               end
               OP_MERGE: begin
                  cmd.idx_clear = 1'b1;
                  state_in      = stat.list_empty ? ST_APPEND : ST_M_RD;
               end
               OP_INCLUDE, OP_EXCLUDE, OP_COUNT: begin
                  if (!stat.in_bw) begin
                     cmd.set_outside = 1'b1;
                     state_in        = ST_DONE;
                  end else begin
                     cmd.idx_clear = 1'b1;
                     if (!stat.list_empty) begin
                        state_in = ST_Q_RD;
                     end else begin
                        state_in = (stat.opcode == OP_COUNT) ? ST_SUM : ST_DONE;
                     end
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_M_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_M_CMP;
         end
         ST_M_CMP: begin
            cmd.cmp_word = 1'b1;
            if (stat.last_word) begin
               state_in = ST_M_DEC;
            end else begin
               cmd.word_next = 1'b1;
               state_in      = ST_M_RD;
            end
         end
         ST_M_DEC: begin
            if (stat.crb_eq && stat.sym_eq && stat.sc_eq) begin
               state_in = ST_DONE;
            end else if (stat.sym_eq && stat.sc_eq) begin
               cmd.word_clear = 1'b1;
               state_in       = ST_M_ORRD;
            end else if (stat.crb_eq && stat.sym_eq) begin
               cmd.sc_or = 1'b1;
               state_in  = ST_DONE;
            end else if (stat.crb_eq && stat.sc_eq) begin
               cmd.sym_or = 1'b1;
               state_in   = ST_DONE;
            end else if (!stat.last_entry) begin
               cmd.entry_next = 1'b1;
               state_in       = ST_M_RD;
            end else if (stat.list_full) begin
               cmd.set_full = 1'b1;
               state_in     = ST_DONE;
            end else begin
               cmd.word_clear = 1'b1;
               state_in       = ST_APPEND;
            end
         end
         ST_M_ORRD: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_M_ORWR;
         end
         ST_M_ORWR: begin
            cmd.mem_wr = 1'b1;
            if (stat.last_word) begin
               state_in = ST_DONE;
            end else begin
               cmd.word_next = 1'b1;
               state_in      = ST_M_ORRD;
            end
         end
         ST_APPEND: begin
            cmd.mem_wr   = 1'b1;
            cmd.addr_sel = ADDR_TAIL;
            if (stat.last_word) begin
               cmd.append_meta = 1'b1;
               state_in        = ST_DONE;
            end else begin
               cmd.word_next = 1'b1;
            end
         end
         ST_Q_RD: begin
            cmd.mem_rd   = 1'b1;
            cmd.addr_sel = ADDR_QUERY;
            state_in     = ST_Q_ACC;
         end
         ST_Q_ACC: begin
            cmd.query_acc = 1'b1;
            if (!stat.last_entry) begin
               cmd.entry_next = 1'b1;
               state_in       = ST_Q_RD;
            end else begin
               state_in = (stat.opcode == OP_COUNT) ? ST_SUM : ST_DONE;
            end
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (stat.last_sym) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

@@ hdl/rplm_dp.sv @@
// ----------------------------------------------------------------------------
// RE pattern list mask engine datapath
// Staging words, pattern memory and masks, per-symbol union, count and results.
// ----------------------------------------------------------------------------
module rplm_dp
   import rplm_pkg::*;
#(
   parameter int MAX_PRB      = MAX_PRB_DEF,
   parameter int SYMS         = SYMS_DEF,
   parameter int MAX_PATTERNS = MAX_PATTERNS_DEF
)(
   input  logic          clock,
   input  logic          reset,
   input  rplm_cmd_type  cmd,
   output rplm_stat_type stat,
   input  logic [2:0]    req_opcode,
   input  logic [2:0]    req_word_index,
   input  logic [63:0]   req_crb_word,
   input  logic [13:0]   req_symbol_mask,
   input  logic [11:0]   req_subcarrier_mask,
   input  logic [3:0]    req_symbol,
   input  logic [3:0]    req_symbol_count,
   input  logic [8:0]    req_prb,
   input  logic [11:0]   req_mask_in,
   input  logic          req_restart,
   input  logic          csr_wr_en,
   input  logic [8:0]    csr_wr_data,
   output logic [11:0]   rsp_mask_out,
   output logic [15:0]   rsp_running_count,
   output logic [1:0]    rsp_status
);

   localparam int NWORDS = (MAX_PRB + 63) / 64;
   localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int IW     = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int TW     = $clog2(MAX_PATTERNS + 1);
   localparam int AW     = (MAX_PATTERNS * NWORDS > 1) ? $clog2(MAX_PATTERNS * NWORDS) : 1;
   localparam int SW     = $clog2(SYMS);
   localparam int DEPTH  = MAX_PATTERNS * NWORDS;

   // captured request
   logic [2:0]            opcode_ff;
   logic [2:0]            widx_ff;
   logic [63:0]           word_ff;
   logic [SYMS-1:0]       symmask_ff;
   logic [11:0]           scmask_ff;
   logic [3:0]            symbol_ff;
   logic [3:0]            nsym_ff;
   logic [8:0]            prb_ff;
   logic [11:0]           mask_in_ff;

   logic [8:0]            num_prb_ff;
   logic [63:0]           staged_ff [NWORDS];
   logic [SYMS-1:0]       pat_sym_ff [MAX_PATTERNS];
   logic [11:0]           pat_sc_ff [MAX_PATTERNS];
   logic [TW-1:0]         total_ff;
   logic [15:0]           acc_ff;
   logic [WW-1:0]         w_ff;
   logic [IW-1:0]         i_ff;
   logic [SW-1:0]         s_ff;
   logic                  eq_ff;
   logic [11:0]           union_ff [SYMS];
   logic [1:0]            status_ff;

   logic [63:0]           mem [DEPTH];
   logic [63:0]           rdata_ff;
   logic [AW-1:0]         addr;
   logic [63:0]           wdata;

   logic [63:0]           load_mask;
   logic [8:0]            bw;
   logic [11:0]           u_sel;
   logic [4:0]            win_end;
   logic [16:0]           sum;

   assign bw = (num_prb_ff < 9'(MAX_PRB)) ? num_prb_ff : 9'(MAX_PRB);

   always_comb begin
      for (int b = 0; b < 64; b++) begin
         load_mask[b] = (int'(widx_ff) * 64 + b) < MAX_PRB;
      end
   end

   always_comb begin
      case (cmd.addr_sel)
         ADDR_TAIL:  addr = AW'(total_ff) * AW'(NWORDS) + AW'(w_ff);
         ADDR_QUERY: addr = AW'(i_ff) * AW'(NWORDS) + AW'(prb_ff[8:6]);
         default:    addr = AW'(i_ff) * AW'(NWORDS) + AW'(w_ff);
      endcase
      wdata = (cmd.addr_sel == ADDR_TAIL) ? staged_ff[w_ff] : (rdata_ff | staged_ff[w_ff]);
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[addr] <= wdata;
      end
      if (cmd.mem_rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign win_end = {1'b0, symbol_ff} +
                    ((opcode_ff == OP_COUNT) ? {1'b0, nsym_ff} : 5'd1);

   always_comb begin
      u_sel = '0;
      for (int s = 0; s < SYMS; s++) begin
         if (symbol_ff == 4'(s)) begin
            u_sel = union_ff[s];
         end
      end
   end

   assign sum = {1'b0, acc_ff} + {13'd0, popcount12(union_ff[s_ff])};

   // payload captures
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff  <= req_opcode;
         widx_ff    <= req_word_index;
         word_ff    <= req_crb_word;
         symmask_ff <= req_symbol_mask[SYMS-1:0];
         scmask_ff  <= req_subcarrier_mask;
         symbol_ff  <= req_symbol;
         nsym_ff    <= req_symbol_count;
         prb_ff     <= req_prb;
         mask_in_ff <= req_mask_in;
      end
      if (cmd.sc_or) begin
         pat_sc_ff[i_ff] <= pat_sc_ff[i_ff] | scmask_ff;
      end
      if (cmd.sym_or) begin
         pat_sym_ff[i_ff] <= pat_sym_ff[i_ff] | symmask_ff;
      end
      if (cmd.append_meta) begin
         pat_sym_ff[IW'(total_ff)] <= symmask_ff;
         pat_sc_ff[IW'(total_ff)]  <= scmask_ff;
      end
      if (cmd.idx_clear) begin
         for (int s = 0; s < SYMS; s++) begin
            union_ff[s] <= '0;
         end
      end else if (cmd.query_acc && rdata_ff[prb_ff[5:0]]) begin
         for (int s = 0; s < SYMS; s++) begin
            if (pat_sym_ff[i_ff][s] && (5'(s) >= {1'b0, symbol_ff}) && (5'(s) < win_end)) begin
               union_ff[s] <= union_ff[s] | pat_sc_ff[i_ff];
            end
         end
      end
      if (cmd.out_load) begin
         rsp_running_count <= acc_ff;
         rsp_status        <= status_ff;
         if (status_ff == STATUS_OK && opcode_ff == OP_INCLUDE) begin
            rsp_mask_out <= mask_in_ff | u_sel;
         end else if (status_ff == STATUS_OK && opcode_ff == OP_EXCLUDE) begin
            rsp_mask_out <= mask_in_ff & ~u_sel;
         end else begin
            rsp_mask_out <= mask_in_ff;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_prb_ff <= 9'(MAX_PRB_DEF);
         total_ff   <= '0;
         acc_ff     <= '0;
         status_ff  <= STATUS_OK;
         w_ff       <= '0;
         i_ff       <= '0;
         s_ff       <= '0;
         eq_ff      <= 1'b1;
         for (int w = 0; w < NWORDS; w++) begin
            staged_ff[w] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            num_prb_ff <= csr_wr_data;
         end
         if (cmd.capture) begin
            status_ff <= STATUS_OK;
            if (req_opcode == OP_COUNT && req_restart) begin
               acc_ff <= '0;
            end
         end
         if (cmd.list_clear) begin
            total_ff <= '0;
         end
         if (cmd.stage_load && (int'(widx_ff) < NWORDS)) begin
            staged_ff[widx_ff[WW-1:0]] <= word_ff & load_mask;
         end
         if (cmd.idx_clear) begin
            w_ff  <= '0;
            i_ff  <= '0;
            s_ff  <= '0;
            eq_ff <= 1'b1;
         end
         if (cmd.word_clear) begin
            w_ff <= '0;
         end
         if (cmd.word_next) begin
            w_ff <= w_ff + 1'b1;
         end
         if (cmd.entry_next) begin
            i_ff  <= i_ff + 1'b1;
            w_ff  <= '0;
            eq_ff <= 1'b1;
         end
         if (cmd.cmp_word) begin
            eq_ff <= eq_ff && (rdata_ff == staged_ff[w_ff]);
         end
         if (cmd.append_meta) begin
            total_ff <= total_ff + 1'b1;
         end
         if (cmd.set_full) begin
            status_ff <= STATUS_FULL;
         end
         if (cmd.set_outside) begin
            status_ff <= STATUS_OUTSIDE;
         end
         if (cmd.sum_step) begin
            s_ff   <= s_ff + 1'b1;
            acc_ff <= sum[16] ? 16'hFFFF : sum[15:0];
         end
      end
   end

   always_comb begin
      stat.opcode     = opcode_ff;
      stat.in_bw      = prb_ff < bw;
      stat.list_empty = (total_ff == '0);
      stat.list_full  = (total_ff == TW'(MAX_PATTERNS));
      stat.last_word  = (w_ff == WW'(NWORDS - 1));
      stat.last_entry = ({{(TW > IW ? TW - IW : 0){1'b0}}, i_ff} + TW'(1)) == total_ff;
      stat.last_sym   = (s_ff == SW'(SYMS - 1));
      stat.crb_eq     = eq_ff;
      stat.sym_eq     = (pat_sym_ff[i_ff] == symmask_ff);
      stat.sc_eq      = (pat_sc_ff[i_ff] == scmask_ff);
   end

endmodule
